// ===== rtl/mavg_pkg.sv =====
// Package for the moving-average window block.
// Holds sizing constants, the FSM state type, the divider status struct and the length clamp.
// No dependencies.
package mavg_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;

    // Derived sizes
    localparam int POS_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
    localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
    localparam int CNT_BITS    = $clog2(DIV_BITS + 1);
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((AVG_BITS + 7) / 8) * 8;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(8);
    localparam logic [LEN_BITS-1:0] LEN_MIN   = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_START  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_HOLD   = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a written length into 1..MAX_WINDOW.
    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS-1:0] r;
        if (v == '0) begin
            r = LEN_MIN;
        end else if (v > LEN_MAX) begin
            r = LEN_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/mavg_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// Standalone; used for the sample ring store.
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mavg_div.sv =====
// Bit-serial restoring divider: unsigned dividend by the window length.
// One quotient bit per cycle. Depends on mavg_pkg.
module mavg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [mavg_pkg::DIV_BITS-1:0]     dividend,
    input  logic [mavg_pkg::LEN_BITS-1:0]     divisor,
    output mavg_pkg::div_stat_t               stat,
    output logic [mavg_pkg::DIV_BITS-1:0]     quotient
);
    import mavg_pkg::*;

    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [LEN_BITS:0]   rem_reg, rem_next;
    logic [LEN_BITS-1:0] dsr_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg, done_reg;
    logic [LEN_BITS:0]   trial;
    logic                fits;

    // Shift in the next dividend bit, subtract if the divisor fits.
    always_comb begin
        trial    = {rem_reg[LEN_BITS-1:0], quo_reg[DIV_BITS-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;
        quo_next = {quo_reg[DIV_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIV_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/moving_average_window.sv =====
// Moving-average window, top level.
// Depends on mavg_pkg, mavg_ram (sample ring store) and mavg_div (serial divider).
//
// Channels: s_* takes one signed sample per transfer (s_tdata, low bits); m_* gives
// one average per sample, signed, 8 fraction bits, truncated toward zero.
// cfg_we/cfg_wdata write window_length (0 reads as 1, above 64 saturates to 64).
// Every write, even of the same value, empties the window; write only while idle.
//
// Flow: one sample at a time, through these steps from its transfer to its result on
// m_*: the ring-store read and running-sum update, the divider load, the bit-serial
// divide (one quotient bit per cycle over the 30-bit scaled sum), the divider's done
// flag, and the move of the quotient to m_*. s_tready is high only while idle, so a
// new sample is taken only after the last one's result has reached the output
// register. A result may wait on m_* while the next sample is worked on; if the
// receiver stalls and a second result is ready, the block holds it and keeps
// s_tready low until the output register frees up.
//
// Reset: length 8, running sum and write position zero; per-entry valid bits
// make every store entry read as zero at once, so no clearing pass is needed.
module moving_average_window (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config
    input  logic                                  cfg_we,
    input  logic [mavg_pkg::LEN_BITS-1:0]         cfg_wdata,  // window_length
    // sample input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mavg_pkg::S_TDATA_BITS-1:0]     s_tdata,    // [15:0] sample
    // average output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mavg_pkg::M_TDATA_BITS-1:0]     m_tdata     // [23:0] average
);
    import mavg_pkg::*;

    state_t                 state_reg, state_next;
    logic [LEN_BITS-1:0]    len_reg;
    logic [POS_BITS-1:0]    pos_reg;       // next ring slot to overwrite
    logic [POS_BITS-1:0]    addr_reg;      // slot of the sample in flight
    logic [SUM_BITS-1:0]    sum_reg;
    logic [MAX_WINDOW-1:0]  valid_reg;     // slot written since last clear
    logic                   old_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   sign_reg;
    logic                   out_valid_reg;
    logic [AVG_BITS-1:0]    out_data_reg;

    logic                   accept;
    logic [POS_BITS-1:0]    pos_eff;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_BITS-1:0]    sum_next;
    logic [LEN_BITS:0]      pos_inc;
    logic [POS_BITS-1:0]    pos_wrap;
    logic [SUM_BITS-1:0]    sum_mag;
    logic [DIV_BITS-1:0]    dividend;
    logic [DIV_BITS-1:0]    quotient;
    logic [AVG_BITS-1:0]    avg_mag;
    logic [AVG_BITS-1:0]    avg_val;
    logic                   out_free;
    div_stat_t              div_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Position guard: wrap to slot 0 if it ever sits at or past the length.
    assign pos_eff = ({1'b0, pos_reg} >= len_reg) ? '0 : pos_reg;

    // Read the slot about to be replaced; the write-back happens in ST_UPDATE,
    // before the next read can issue, so no forwarding is needed.
    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .aclk  (aclk),
        .we    (state_reg == ST_UPDATE),
        .waddr (addr_reg),
        .wdata (sample_reg),
        .re    (accept),
        .raddr (pos_eff),
        .rdata (ram_rdata)
    );

    // Running-sum update: add new sample, drop the one leaving the window.
    always_comb begin
        old_sample = old_valid_reg ? ram_rdata : '0;
        sum_next   = sum_reg
                   + {{(SUM_BITS-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg}
                   - {{(SUM_BITS-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
        pos_inc    = {1'b0, {(LEN_BITS-POS_BITS){1'b0}}, addr_reg} + 1'b1;
        pos_wrap   = (pos_inc >= {1'b0, len_reg}) ? '0 : pos_inc[POS_BITS-1:0];
    end

    // Divide the magnitude of sum * 256, restore the sign afterwards.
    assign sum_mag  = sum_reg[SUM_BITS-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign dividend = {sum_mag, {FRAC_BITS{1'b0}}};

    mavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_START),
        .dividend (dividend),
        .divisor  (len_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign avg_mag = quotient[AVG_BITS-1:0];
    assign avg_val = sign_reg ? (~avg_mag + 1'b1) : avg_mag;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_START;
            ST_START:  state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_stat.done) state_next = ST_HOLD;
            ST_HOLD:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            pos_reg       <= '0;
            sum_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                // empties the window
                len_reg   <= clamp_len(cfg_wdata);
                pos_reg   <= '0;
                sum_reg   <= '0;
                valid_reg <= '0;
            end else if (state_reg == ST_UPDATE) begin
                sum_reg             <= sum_next;
                pos_reg             <= pos_wrap;
                valid_reg[addr_reg] <= 1'b1;
            end
            if (state_reg == ST_HOLD && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg    <= s_tdata[SAMPLE_BITS-1:0];
            addr_reg      <= pos_eff;
            old_valid_reg <= valid_reg[pos_eff];
        end
        if (state_reg == ST_START) begin
            sign_reg <= sum_reg[SUM_BITS-1];
        end
        if (state_reg == ST_HOLD && out_free) begin
            out_data_reg <= avg_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(out_data_reg);

    // Assertions

    // The divider only finishes while the FSM is waiting for it.
    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside divide state");

    // Write position always lies inside the current window.
    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, pos_reg} < len_reg))
        else $error("write position outside window");

    // An empty window must have a zero running sum.
    a_empty_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero with empty window");

    // A sample transfer is followed in the next cycle by ST_UPDATE, with s_tready low.
    a_accept_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_UPDATE) && !s_tready)
        else $error("sample transfer not followed by update");

endmodule

// ===== sim/moving_average_window_tb.sv =====
// Testbench for moving_average_window: directed table, then random sample bursts
// under several window lengths, every average checked against a typed value or a local predictor.
// Depends on mavg_pkg and the moving_average_window RTL.
module moving_average_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RAND_ITEMS   = 1950;
    localparam int PHASES       = 12;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;

    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Length written at the start of each random phase; -1 picks a random value in 1..127.
    // Covers zero, one, the window depth, values past it and the all-ones code.
    localparam int LEN_PLAN [PHASES] = '{64, 1, 0, 127, -1, 65, 2, -1, 63, 8, -1, 33};

    typedef enum logic { ROW_LEN, ROW_SMP } row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        val;    // length code or sample
        bit        chk;    // average typed in below
        int        avg;
    } row_t;

    // Directed rows. Typed averages are sum * 256 / length, truncated toward zero.
    localparam int DIR_ROWS = 28;
    row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SMP,  32767, 1'b1,  1048544},  // reset length 8, positive extreme
        '{ROW_SMP, -32768, 1'b1,      -32},  // negative extreme, sum -1
        '{ROW_SMP,      0, 1'b0,        0},
        '{ROW_SMP,  12345, 1'b0,        0},
        '{ROW_LEN,      1, 1'b0,        0},
        '{ROW_SMP,  32767, 1'b1,  8388352},  // largest average
        '{ROW_SMP, -32768, 1'b1, -8388608},  // smallest average
        '{ROW_LEN,      0, 1'b0,        0},  // zero length reads as one
        '{ROW_SMP,      5, 1'b1,     1280},
        '{ROW_LEN,    127, 1'b0,        0},  // saturates to 64
        '{ROW_SMP,  32767, 1'b1,   131068},
        '{ROW_SMP,     -1, 1'b0,        0},
        '{ROW_LEN,     65, 1'b0,        0},  // just past the depth
        '{ROW_SMP, -32768, 1'b1,  -131072},
        '{ROW_LEN,      2, 1'b0,        0},
        '{ROW_SMP, -32768, 1'b1, -4194304},
        '{ROW_SMP, -32768, 1'b1, -8388608},  // full window of minimum samples
        '{ROW_SMP,      1, 1'b0,        0},
        '{ROW_LEN,      3, 1'b0,        0},
        '{ROW_SMP,     -1, 1'b1,      -85},  // truncation toward zero, not floor
        '{ROW_SMP,    100, 1'b0,        0},
        '{ROW_LEN,      3, 1'b0,        0},  // same length again still empties window
        '{ROW_SMP,      0, 1'b1,        0},
        '{ROW_LEN,     64, 1'b0,        0},
        '{ROW_SMP, -32768, 1'b1,  -131072},
        '{ROW_SMP,  32767, 1'b0,        0},
        '{ROW_SMP,  21845, 1'b0,        0},  // 0x5555
        '{ROW_SMP, -21846, 1'b0,        0}   // 0xAAAA
    };

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [LEN_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // Predictor state: ring of samples, write slot, running sum and active length.
    logic signed [SAMPLE_BITS-1:0] win_samples [MAX_WINDOW];
    int                            win_pos;
    int                            win_len;
    longint                        win_sum;

    logic [AVG_BITS-1:0] pending_averages [$];  // oldest expected average first
    logic [AVG_BITS-1:0] want_avg;
    int                  fault_count = 0;
    int                  cycle_count = 0;

    // Sample generator state: runs of one value, long enough to fill whole windows at times.
    logic [SAMPLE_BITS-1:0] run_val = '0;
    int                     run_left = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_left = 0;

    moving_average_window i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Length write: clamp to 1..depth and empty the window, whatever the old value.
    function automatic void set_length(input logic [LEN_BITS-1:0] code);
        if (code == '0) begin
            win_len = 1;
        end else if (int'(code) > MAX_WINDOW) begin
            win_len = MAX_WINDOW;
        end else begin
            win_len = int'(code);
        end
        foreach (win_samples[i]) begin
            win_samples[i] = '0;
        end
        win_pos = 0;
        win_sum = 0;
    endfunction

    // Push one sample into the window and return the new mean, 8 fraction bits.
    function automatic logic [AVG_BITS-1:0] next_average(input logic signed [SAMPLE_BITS-1:0] smp);
        longint scaled;
        if (win_pos >= win_len) begin
            win_pos = 0;
        end
        win_sum += longint'(smp) - longint'(win_samples[win_pos]);
        win_samples[win_pos] = smp;
        win_pos++;
        if (win_pos >= win_len) begin
            win_pos = 0;
        end
        scaled = (win_sum * 256) / win_len;  // SV division truncates toward zero
        return AVG_BITS'(scaled);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        if (run_left > 0) begin
            run_left--;
            return run_val;
        end
        case ($urandom_range(0, 19))
            0: begin
                // long run, often an extreme, to saturate the sum at any length
                run_left = $urandom_range(1, 80);
                case ($urandom_range(0, 2))
                    0:       run_val = SMP_MAX;
                    1:       run_val = SMP_MIN;
                    default: run_val = SAMPLE_BITS'($urandom);
                endcase
                return run_val;
            end
            1, 2:       return SMP_MAX;
            3, 4:       return SMP_MIN;
            5, 6, 7, 8: return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
            default:    return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Present one sample and hold it until the transfer; valid stays high on return
    // so a following call in the same step makes the only assignment to it.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input bit chk, input int avg);
        logic [AVG_BITS-1:0] predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(smp);
        do @(posedge aclk); while (!s_tready);
        predicted = next_average(smp);
        pending_averages.push_back(chk ? AVG_BITS'(avg) : predicted);
    endtask

    // Sender gap; n is at least one.
    task automatic hold_off(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Stop sending until every expected average has come, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(input logic [LEN_BITS-1:0] code);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        set_length(code);
    endtask

    // Result side: check each transfer against the oldest expectation, then pick
    // the next ready value from the current stall pattern.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_averages.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("unexpected average %0d with none pending",
                             $signed(m_tdata[AVG_BITS-1:0]));
                end
            end else begin
                want_avg = pending_averages.pop_front();
                if (m_tdata[AVG_BITS-1:0] !== want_avg) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX) begin
                        $display("average mismatch: expected %0d (%h) got %0d (%h)",
                                 $signed(want_avg), want_avg,
                                 $signed(m_tdata[AVG_BITS-1:0]), m_tdata[AVG_BITS-1:0]);
                    end
                end
            end
        end

        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(1, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;                          // no stalls
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
            default: m_tready <= ((stall_left % 8) < 5);        // periodic
        endcase
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("moving_average_window test failed");
        $finish;
    end

    initial begin
        logic [LEN_BITS-1:0] len_code;
        int                  burst_left;

        set_length(LEN_RESET);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, back to back
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_LEN) begin
                write_length(LEN_BITS'(dir_rows[i].val));
            end else begin
                send_sample(SAMPLE_BITS'(dir_rows[i].val), dir_rows[i].chk, dir_rows[i].avg);
            end
        end

        // Random part: one length per phase, samples in bursts with gaps before most of them.
        burst_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            if (LEN_PLAN[p] < 0) begin
                len_code = LEN_BITS'($urandom_range(1, 127));
            end else begin
                len_code = LEN_BITS'(LEN_PLAN[p]);
            end
            write_length(len_code);
            for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 24) == 0) begin
                        wait_drained();
                    end else if ($urandom_range(0, 2) != 0) begin
                        hold_off($urandom_range(1, 20));
                    end
                end
                burst_left--;
                send_sample(pick_sample(), 1'b0, 0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("moving_average_window test passed");
        end else begin
            $display("moving_average_window test failed");
        end
        $finish;
    end

endmodule

// ===== moving_average_window.f =====
rtl/mavg_pkg.sv
rtl/mavg_ram.sv
rtl/mavg_div.sv
rtl/moving_average_window.sv
sim/moving_average_window_tb.sv
